// File: hw/rtl/drti_pkg.sv
package drti_pkg;

  typedef enum logic [1:0] {
    MODE_TRUNC = 2'd0,
    MODE_FLOOR = 2'd1,
    MODE_CEIL  = 2'd2,
    MODE_RSVD  = 2'd3
  } mode_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [63:0] operand_bits;
  } drti_req_t;

  typedef struct packed {
    logic [63:0] rounded_bits;
    logic [63:0] fraction_bits;
  } drti_rsp_t;

  localparam logic [10:0] EXP_BIAS     = 11'd1023;
  localparam logic [10:0] EXP_BIG      = 11'd1075;
  localparam logic [10:0] EXP_SPECIAL  = 11'h7FF;
  localparam logic [63:0] DEFAULT_QNAN = 64'h7FF8_0000_0000_0000;
  localparam logic [63:0] QUIET_BIT    = 64'h0008_0000_0000_0000;
  localparam logic [63:0] POS_ONE      = 64'h3FF0_0000_0000_0000;
  localparam logic [63:0] NEG_ONE      = 64'hBFF0_0000_0000_0000;

endpackage

// File: hw/rtl/double_round_to_integral.sv
// Rounds a binary64 operand by truncation, floor or ceil and also returns the exact
// fractional part. One request is accepted per cycle while the pipe is not stalled;
// a request taken passes the input register and then the result register before its
// result can be taken. The result register holds it until taken, and only a stalled
// full pipe holds off the input. Mode 3 acts as truncate.
module double_round_to_integral
  import drti_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  drti_req_t in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output drti_rsp_t out_data
);

  drti_req_t req_r;
  logic      req_vld_r;
  drti_rsp_t rsp;
  drti_rsp_t out_r;
  logic      out_vld_r;
  logic      adv;

  assign adv      = !out_vld_r || out_ready;
  assign in_ready = !req_vld_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_ready) req_vld_r <= in_valid;
      if (adv) out_vld_r <= req_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) req_r <= in_data;
    if (adv && req_vld_r) out_r <= rsp;
  end

  drti_core u_core (.req(req_r), .rsp(rsp));

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule

// File: hw/rtl/drti_core.sv
module drti_core
  import drti_pkg::*;
(
  input  drti_req_t req,
  output drti_rsp_t rsp
);

  logic        sign;
  logic [10:0] ex;
  logic [51:0] m;
  logic [52:0] full;
  logic [52:0] low;
  logic [52:0] r;
  logic [52:0] n;
  logic [53:0] n1;
  logic [53:0] n1s;
  logic [5:0]  sh;
  logic        up;
  logic [5:0]  rp;
  logic [5:0]  lz;
  logic [10:0] fex;
  logic [63:0] frac_norm;
  logic [63:0] rnd_up;
  logic [10:0] uex;
  logic [51:0] umant;
  logic [11:0] diff;

  always_comb begin
    sign = req.operand_bits[63];
    ex   = req.operand_bits[62:52];
    m    = req.operand_bits[51:0];
    full = {1'b1, m};
    up   = (mode_t'(req.req_type) == MODE_FLOOR && sign) ||
           (mode_t'(req.req_type) == MODE_CEIL && !sign);
    diff = {1'b0, EXP_BIG} - {1'b0, ex};
    sh   = diff[5:0];
    low  = (53'd1 << sh) - 53'd1;
    r    = full & low;
    n    = full >> sh;
    n1   = {1'b0, n} + 54'd1;
    lz   = 6'd0;
    for (int i = 0; i < 53; i++) begin
      if (r[i]) begin
        lz = 6'(i);
      end
    end
    rp  = lz;
    fex = 11'(EXP_BIAS + 11'(rp) - 11'(sh));
    frac_norm = {sign, fex, 52'((r << (6'd52 - rp)))};
    // carry out of the integer part bumps the exponent
    n1s    = n1 << sh;
    uex    = n1s[53] ? 11'(ex + 11'd1) : ex;
    umant  = n1s[53] ? 52'd0 : n1s[51:0];
    rnd_up = {sign, uex, umant};
    if (ex == EXP_SPECIAL) begin
      rsp.rounded_bits  = req.operand_bits;
      rsp.fraction_bits = (m == 52'd0) ? DEFAULT_QNAN : (req.operand_bits | QUIET_BIT);
    end else if (ex >= EXP_BIG - 11'd23 + 11'd23) begin
      rsp.rounded_bits  = req.operand_bits;
      rsp.fraction_bits = 64'd0;
    end else if (ex < EXP_BIAS) begin
      rsp.fraction_bits = (req.operand_bits[62:0] != 63'd0) ? req.operand_bits : 64'd0;
      rsp.rounded_bits  = 64'd0;
      if (req.operand_bits[62:0] != 63'd0 && up) begin
        rsp.rounded_bits = sign ? NEG_ONE : POS_ONE;
      end
    end else begin
      rsp.rounded_bits  = req.operand_bits & ~{11'd0, low};
      rsp.fraction_bits = (r != 53'd0) ? frac_norm : 64'd0;
      if (r != 53'd0 && up) begin
        rsp.rounded_bits = rnd_up;
      end
    end
  end

endmodule

// File: hw/rtl/drti_checker.sv
module drti_checker
  import drti_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input drti_rsp_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped or changed while stalled");

  a_ready_when_drain: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_valid && in_ready) ##1 (!(in_valid && in_ready) && !out_valid) |=> !out_valid)
    else $error("result without request");

  a_zero_frac_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.fraction_bits != 64'h8000_0000_0000_0000)
    else $error("negative zero fraction");

endmodule

bind double_round_to_integral drti_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
